### rtl/core/prc_pkg.sv
package prc_pkg;

  localparam int LON_W     = 21;
  localparam int LAT_W     = 20;
  localparam int RANK_W    = 7;
  localparam int CNT_W     = 20;
  localparam int RUNS_W    = 32;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int ARITH_W   = 24;

  localparam logic signed [ARITH_W-1:0] LON_HALF = ARITH_W'(180 * 3600);
  localparam logic signed [ARITH_W-1:0] LON_FULL = ARITH_W'(360 * 3600);

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [RUNS_W-1:0] RUNS_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] REG_RANK_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEST      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOUTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 3'd4;

  typedef struct packed {
    logic signed [LON_W-1:0] lon;
    logic signed [LAT_W-1:0] lat;
    logic [RANK_W-1:0]       rank;
    logic                    in_box;
    logic                    eos;
  } prc_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]        longest;
    logic [RUNS_W-1:0]       runs;
    logic [CNT_W-1:0]        run_len;
    logic [RANK_W-1:0]       rank;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
    logic                    end_run;
  } prc_result_t;

endpackage

### rtl/core/polyline_region_clipper.sv
// Polyline region clipper: takes one map point per transaction and emits the points of
// accepted segments that fall inside the configured lat/lon box, cut into runs. A point
// is held back one item since a run's end is only known from the next point. The input
// side takes one point per cycle while the queue is not full; a two-entry queue sits
// between classification and the run logic, and the output register moves one result
// per cycle unless the output is stalled, so a point that both releases the held point
// and ends its segment yields two results and leaves the queue only with the second.
// A result passes through the queue and then the output register before it is valid.
// Write configuration only while the block is idle; the block does not enforce this.
module polyline_region_clipper (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [prc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [prc_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [47:0]                       in_tdata,   // point_lon, point_lat, seg_rank
  input  logic                              in_tlast,   // end_of_segment
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [119:0]                      out_tdata,  // out_lon, out_lat, out_rank,
                                                        // run_length, runs_so_far,
                                                        // longest_run
  output logic                              out_tlast   // end_of_run
);
  import prc_pkg::*;

  prc_item_t   fr_item, q_head;
  prc_result_t res;
  logic        q_full, q_valid, q_pop, push;

  assign push      = in_tvalid && !q_full;
  assign in_tready = !q_full;

  prc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .pt_lon    (in_tdata[LON_W-1:0]),
    .pt_lat    (in_tdata[LON_W+LAT_W-1:LON_W]),
    .pt_rank   (in_tdata[LON_W+LAT_W+RANK_W-1:LON_W+LAT_W]),
    .pt_eos    (in_tlast),
    .item      (fr_item)
  );

  prc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (fr_item),
    .full       (q_full),
    .head_valid (q_valid),
    .head_item  (q_head),
    .pop        (q_pop)
  );

  prc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {res.longest, res.runs, res.run_len, res.rank, res.lat, res.lon};
  assign out_tlast = res.end_run;

endmodule

### rtl/core/prc_front.sv
module prc_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [prc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [prc_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic signed [prc_pkg::LON_W-1:0]  pt_lon,
  input  logic signed [prc_pkg::LAT_W-1:0]  pt_lat,
  input  logic [prc_pkg::RANK_W-1:0]        pt_rank,
  input  logic                              pt_eos,
  output prc_pkg::prc_item_t                item
);
  import prc_pkg::*;

  logic [CFG_W-1:0]        rank_mask_r;
  logic signed [LON_W-1:0] west_r;
  logic signed [LAT_W-1:0] south_r;
  logic [LON_W-1:0]        width_r;
  logic [LAT_W-1:0]        height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_mask_r <= CFG_W'(6);
      west_r      <= '0;
      south_r     <= '0;
      width_r     <= '0;
      height_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RANK_MASK: rank_mask_r <= cfg_wdata;
        REG_WEST:      west_r      <= cfg_wdata[LON_W-1:0];
        REG_SOUTH:     south_r     <= cfg_wdata[LAT_W-1:0];
        REG_WIDTH:     width_r     <= cfg_wdata[LON_W-1:0];
        REG_HEIGHT:    height_r    <= cfg_wdata[LAT_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [ARITH_W-1:0] w, e, s, n, lon, lat, lon_wrapped;
  logic accepted, clip, lon_ok, lat_ok;

  always_comb begin
    w   = ARITH_W'(west_r);
    s   = ARITH_W'(south_r);
    e   = w + $signed({{(ARITH_W-LON_W){1'b0}}, width_r});
    n   = s + $signed({{(ARITH_W-LAT_W){1'b0}}, height_r});
    lon = ARITH_W'(pt_lon);
    lat = ARITH_W'(pt_lat);
    lon_wrapped = lon + LON_FULL;
    // box crossing the antimeridian
    if (e > LON_HALF) lon_ok = (lon >= w) || (lon_wrapped < e);
    else              lon_ok = (lon >= w) && (lon < e);
    lat_ok   = (lat >= s) && (lat < n);
    accepted = !pt_rank[RANK_W-1] && rank_mask_r[pt_rank[RANK_W-2:0]];
    clip     = (width_r != '0) && (height_r != '0);
    item.lon    = pt_lon;
    item.lat    = pt_lat;
    item.rank   = pt_rank;
    item.eos    = pt_eos;
    item.in_box = accepted && (!clip || (lon_ok && lat_ok));
  end

endmodule

### rtl/core/prc_queue.sv
module prc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  prc_pkg::prc_item_t push_item,
  output logic               full,
  output logic               head_valid,
  output prc_pkg::prc_item_t head_item,
  input  logic               pop
);
  import prc_pkg::*;

  prc_item_t  mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_item  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      priority case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

### rtl/core/prc_back.sv
module prc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  prc_pkg::prc_item_t  q_item,
  output logic                q_pop,
  output logic                res_valid,
  input  logic                res_ready,
  output prc_pkg::prc_result_t res
);
  import prc_pkg::*;

  logic                    held_valid_r, held_valid_nxt;
  logic signed [LON_W-1:0] held_lon_r;
  logic signed [LAT_W-1:0] held_lat_r;
  logic [RANK_W-1:0]       held_rank_r;
  logic                    load_held;
  logic [CNT_W-1:0]        run_count_r, run_count_nxt;
  logic [RUNS_W-1:0]       total_r, total_nxt;
  logic [CNT_W-1:0]        max_r, max_nxt;
  logic                    phase_r, phase_nxt;
  logic                    out_valid_r;
  prc_result_t             out_r, res_nxt;

  logic have_res, done, can_load, fire, eff_in_box;
  logic [RUNS_W-1:0] total_inc;
  logic [CNT_W-1:0]  run_inc;

  assign can_load  = !out_valid_r || res_ready;
  assign total_inc = (total_r != RUNS_MAX) ? total_r + RUNS_W'(1) : total_r;
  assign run_inc   = (run_count_r != CNT_MAX) ? run_count_r + CNT_W'(1) : run_count_r;
  // second half of a two-result item closes the run just like a rejected point
  assign eff_in_box = q_item.in_box && !phase_r;

  always_comb begin
    held_valid_nxt = held_valid_r;
    run_count_nxt  = run_count_r;
    total_nxt      = total_r;
    max_nxt        = max_r;
    load_held      = 1'b0;
    have_res       = 1'b0;
    done           = 1'b1;
    res_nxt.lon     = held_lon_r;
    res_nxt.lat     = held_lat_r;
    res_nxt.rank    = held_rank_r;
    res_nxt.end_run = 1'b1;
    res_nxt.run_len = run_count_r;
    res_nxt.runs    = total_inc;
    res_nxt.longest = (run_count_r > max_r) ? run_count_r : max_r;
    if (!eff_in_box) begin
      if (held_valid_r) begin
        have_res       = 1'b1;
        held_valid_nxt = 1'b0;
        run_count_nxt  = '0;
        total_nxt      = total_inc;
        max_nxt        = res_nxt.longest;
      end
    end else if (held_valid_r) begin
      have_res        = 1'b1;
      res_nxt.end_run = 1'b0;
      res_nxt.runs    = total_r;
      res_nxt.longest = max_r;
      run_count_nxt   = run_inc;
      load_held       = 1'b1;
      done            = !q_item.eos;
    end else if (q_item.eos) begin
      have_res        = 1'b1;
      res_nxt.lon     = q_item.lon;
      res_nxt.lat     = q_item.lat;
      res_nxt.rank    = q_item.rank;
      res_nxt.run_len = CNT_W'(1);
      res_nxt.longest = (max_r == '0) ? CNT_W'(1) : max_r;
      total_nxt       = total_inc;
      max_nxt         = res_nxt.longest;
      run_count_nxt   = '0;
    end else begin
      held_valid_nxt = 1'b1;
      run_count_nxt  = CNT_W'(1);
      load_held      = 1'b1;
    end
  end

  assign fire      = q_valid && (!have_res || can_load);
  assign q_pop     = fire && done;
  assign phase_nxt = !done;
  assign res_valid = out_valid_r;
  assign res       = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      run_count_r  <= '0;
      total_r      <= '0;
      max_r        <= '0;
      phase_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (fire) begin
        held_valid_r <= held_valid_nxt;
        run_count_r  <= run_count_nxt;
        total_r      <= total_nxt;
        max_r        <= max_nxt;
        phase_r      <= phase_nxt;
      end
      if (can_load) out_valid_r <= fire && have_res;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && load_held) begin
      held_lon_r  <= q_item.lon;
      held_lat_r  <= q_item.lat;
      held_rank_r <= q_item.rank;
    end
    if (fire && have_res) out_r <= res_nxt;
  end

endmodule

### rtl/core/prc_checker.sv
module prc_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [119:0] out_tdata,
  input logic         out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[67:48] != 20'd0)
    else $error("run length zero");

  a_end_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[99:68] != 32'd0)
    else $error("run end without run count");

  a_longest: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[119:100] >= out_tdata[67:48])
    else $error("longest run below ending run");

  a_longest_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready ##1 out_tvalid |-> out_tdata[119:100] >= $past(out_tdata[119:100]))
    else $error("longest run decreased");

endmodule

bind polyline_region_clipper prc_checker u_prc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
